// File: hdl/edmwf_pkg.sv
package edmwf_pkg;

  // Field widths
  localparam int ECHO_W   = 20;
  localparam int SCALE_W  = 18;
  localparam int DIST_W   = 15;
  localparam int FRAC_W   = 16;
  localparam int PROD_W   = ECHO_W + SCALE_W;
  localparam int SCALED_W = PROD_W - FRAC_W;

  // Default window depths
  localparam int MEDIAN_TAPS_DEF  = 5;
  localparam int AVERAGE_TAPS_DEF = 5;

  // Configuration port
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 18;

  localparam logic [CFG_INDEX_W-1:0] REG_ECHO_SCALE   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MIN_DISTANCE = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_DISTANCE = 2'd2;

  localparam logic [SCALE_W-1:0] ECHO_SCALE_RST   = 18'd71303;
  localparam logic [DIST_W-1:0]  MIN_DISTANCE_RST = 15'd128;
  localparam logic [DIST_W-1:0]  MAX_DISTANCE_RST = 15'd25600;

  // Controller to datapath commands
  typedef struct packed {
    logic mul;        // register echo times scale
    logic clamp;      // clamp and push into the median window
    logic mload;      // copy median window into the work line
    logic sort_step;  // one odd-even transposition pass
    logic msum_step;  // add one entry of the filling mean
    logic div_start;  // launch the divider
    logic div_avg;    // divider operands come from the averaging stage
    logic med_wb;     // store median and push it into the average window
    logic ainit;      // copy average window into its work line
    logic asum_step;  // add one entry of the weighted sum
    logic out_load;   // fill the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic med_full;   // median window has wrapped
    logic loop_last;  // current loop runs its final step
    logic out_free;   // output register can take a result
  } sts_t;

endpackage

// File: hdl/edmwf_div.sv
module edmwf_div #(
  parameter int NUM_W = 19,
  parameter int DEN_W = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quot,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   rem;
  logic [DEN_W:0]   rem_sh;
  logic [DEN_W+1:0] trial;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] den_r;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    rem_sh = {rem[DEN_W-1:0], quo[NUM_W-1]};
    trial  = {1'b0, rem_sh} - {2'b00, den_r};
  end

  // Control: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(NUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  // Restoring division; quotient bits replace dividend bits
  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (busy) begin
      if (!trial[DEN_W+1]) begin
        rem <= trial[DEN_W:0];
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quot = quo;

endmodule

// File: hdl/edmwf_dp.sv
module edmwf_dp #(
  parameter int MEDIAN_TAPS  = edmwf_pkg::MEDIAN_TAPS_DEF,
  parameter int AVERAGE_TAPS = edmwf_pkg::AVERAGE_TAPS_DEF,
  parameter int NUM_W        = 19,
  parameter int DEN_W        = 4
) (
  input  logic                               clk,
  input  logic                               rst,
  input  edmwf_pkg::cmd_t                    cmd,
  output edmwf_pkg::sts_t                    sts,
  input  logic [edmwf_pkg::ECHO_W-1:0]       echo_us,
  input  logic                               cfg_valid,
  input  logic [edmwf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [edmwf_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic [NUM_W-1:0]                   div_num,
  output logic [DEN_W-1:0]                   div_den,
  input  logic [NUM_W-1:0]                   div_quot,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [edmwf_pkg::DIST_W-1:0]       raw_distance,
  output logic [edmwf_pkg::DIST_W-1:0]       median_distance,
  output logic [edmwf_pkg::DIST_W-1:0]       filtered_distance
);

  localparam int DW      = edmwf_pkg::DIST_W;
  localparam int MT      = MEDIAN_TAPS;
  localparam int AT      = AVERAGE_TAPS;
  localparam int MID     = MT / 2;
  localparam int MCNT_W  = $clog2(MT + 1);
  localparam int ACNT_W  = $clog2(AT + 1);
  localparam int MSUM_W  = DW + $clog2(MT);
  localparam int ASUM_W  = DW + $clog2(AT + 1);
  localparam int ADEN_W  = $clog2(AT * (AT + 1) / 2 + 1);
  localparam int AWT_W   = DW + ADEN_W;
  localparam int LOOP_W  = $clog2(((MT > AT) ? MT : AT) + 1);

  logic [edmwf_pkg::SCALE_W-1:0]  echo_scale;
  logic [DW-1:0]                  min_distance;
  logic [DW-1:0]                  max_distance;
  logic [edmwf_pkg::PROD_W-1:0]   product;
  logic [edmwf_pkg::SCALED_W-1:0] scaled;
  logic [DW-1:0]                  clamped;
  logic [DW-1:0]                  raw;
  logic [DW-1:0]                  med;
  logic [DW-1:0]                  med_value;

  logic [DW-1:0]     mwin [MT];
  logic [DW-1:0]     work [MT];
  logic [DW-1:0]     work_sorted [MT];
  logic [MCNT_W-1:0] mcount;
  logic [MSUM_W-1:0] msum;
  logic              odd;
  logic              med_full;
  logic [LOOP_W-1:0] left;

  logic [DW-1:0]     awin [AT];
  logic [DW-1:0]     awork [AT];
  logic [ACNT_W-1:0] acount;
  logic [ASUM_W-1:0] asum;
  logic [ASUM_W-1:0] asum_next;
  logic [AWT_W-1:0]  awsum;
  logic [ADEN_W-1:0] aden;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      echo_scale   <= edmwf_pkg::ECHO_SCALE_RST;
      min_distance <= edmwf_pkg::MIN_DISTANCE_RST;
      max_distance <= edmwf_pkg::MAX_DISTANCE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        edmwf_pkg::REG_ECHO_SCALE:   echo_scale   <= cfg_data[edmwf_pkg::SCALE_W-1:0];
        edmwf_pkg::REG_MIN_DISTANCE: min_distance <= cfg_data[DW-1:0];
        edmwf_pkg::REG_MAX_DISTANCE: max_distance <= cfg_data[DW-1:0];
        default: ;
      endcase
    end
  end

  // Scale: echo width times Q16 factor
  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      product <= edmwf_pkg::PROD_W'(echo_us) * edmwf_pkg::PROD_W'(echo_scale);
    end
  end

  // Clamp; with crossed limits, below min gives min, else max
  always_comb begin
    scaled = product[edmwf_pkg::PROD_W-1:edmwf_pkg::FRAC_W];
    if (scaled < edmwf_pkg::SCALED_W'(min_distance)) begin
      clamped = min_distance;
    end else if (scaled > edmwf_pkg::SCALED_W'(max_distance)) begin
      clamped = max_distance;
    end else begin
      clamped = scaled[DW-1:0];
    end
  end

  assign med_full = (mcount == MCNT_W'(MT));

  // One odd-even transposition pass over disjoint pairs
  always_comb begin
    for (int i = 0; i < MT; i++) begin
      work_sorted[i] = work[i];
    end
    for (int i = 0; i < MT - 1; i++) begin
      if ((i % 2 == 1) == odd && work[i] > work[i+1]) begin
        work_sorted[i]   = work[i+1];
        work_sorted[i+1] = work[i];
      end
    end
  end

  // Median window, newest entry first
  always_ff @(posedge clk) begin
    if (cmd.clamp) begin
      raw     <= clamped;
      mwin[0] <= clamped;
      for (int i = 1; i < MT; i++) begin
        mwin[i] <= mwin[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mcount <= '0;
    end else if (cmd.clamp && !med_full) begin
      mcount <= mcount + MCNT_W'(1);
    end
  end

  // Median work line: sort passes or mean accumulation
  always_ff @(posedge clk) begin
    if (cmd.mload) begin
      for (int i = 0; i < MT; i++) begin
        work[i] <= mwin[i];
      end
      odd  <= 1'b0;
      msum <= '0;
    end else if (cmd.sort_step) begin
      for (int i = 0; i < MT; i++) begin
        work[i] <= work_sorted[i];
      end
      odd <= !odd;
    end else if (cmd.msum_step) begin
      msum <= msum + MSUM_W'(work[0]);
      for (int i = 0; i < MT - 1; i++) begin
        work[i] <= work[i+1];
      end
      work[MT-1] <= '0;
    end
  end

  // Loop counter shared by all stepped phases
  always_ff @(posedge clk) begin
    if (cmd.mload) begin
      left <= med_full ? LOOP_W'(MT) : LOOP_W'(mcount);
    end else if (cmd.ainit) begin
      left <= LOOP_W'(acount);
    end else if (cmd.sort_step || cmd.msum_step || cmd.asum_step) begin
      left <= left - LOOP_W'(1);
    end
  end

  // Median result: middle of sorted line, or filling mean
  assign med_value = med_full ? work[MID] : div_quot[DW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.med_wb) begin
      med     <= med_value;
      awin[0] <= med_value;
      for (int i = 1; i < AT; i++) begin
        awin[i] <= awin[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acount <= '0;
    end else if (cmd.med_wb && acount != ACNT_W'(AT)) begin
      acount <= acount + ACNT_W'(1);
    end
  end

  // Weighted sum, newest first: running sum added once per step
  assign asum_next = asum + ASUM_W'(awork[0]);

  always_ff @(posedge clk) begin
    if (cmd.ainit) begin
      for (int i = 0; i < AT; i++) begin
        awork[i] <= awin[i];
      end
      asum  <= '0;
      awsum <= '0;
      aden  <= '0;
    end else if (cmd.asum_step) begin
      asum  <= asum_next;
      awsum <= awsum + AWT_W'(asum_next);
      aden  <= aden + ADEN_W'(left);
      for (int i = 0; i < AT - 1; i++) begin
        awork[i] <= awork[i+1];
      end
      awork[AT-1] <= '0;
    end
  end

  // Divider operands
  assign div_num = cmd.div_avg ? NUM_W'(awsum) : NUM_W'(msum);
  assign div_den = cmd.div_avg ? DEN_W'(aden) : DEN_W'(mcount);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      raw_distance      <= raw;
      median_distance   <= med;
      filtered_distance <= div_quot[DW-1:0];
    end
  end

  always_comb begin
    sts.med_full  = med_full;
    sts.loop_last = (left == LOOP_W'(1));
    sts.out_free  = !out_valid || out_ready;
  end

endmodule

// File: hdl/edmwf_ctrl.sv
module edmwf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  edmwf_pkg::sts_t sts,
  input  logic            div_done,
  output edmwf_pkg::cmd_t cmd
);

  typedef enum logic [12:0] {
    S_IDLE  = 13'b0000000000001,
    S_CLAMP = 13'b0000000000010,
    S_MLOAD = 13'b0000000000100,
    S_SORT  = 13'b0000000001000,
    S_MSUM  = 13'b0000000010000,
    S_MDIVS = 13'b0000000100000,
    S_MDIV  = 13'b0000001000000,
    S_MWB   = 13'b0000010000000,
    S_AINIT = 13'b0000100000000,
    S_ASUM  = 13'b0001000000000,
    S_ADIVS = 13'b0010000000000,
    S_ADIV  = 13'b0100000000000,
    S_DONE  = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence one request through scale, median, average and output
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.mul    = 1'b1;
          state_next = S_CLAMP;
        end
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_MLOAD;
      end
      S_MLOAD: begin
        cmd.mload  = 1'b1;
        state_next = sts.med_full ? S_SORT : S_MSUM;
      end
      S_SORT: begin
        cmd.sort_step = 1'b1;
        if (sts.loop_last) begin
          state_next = S_MWB;
        end
      end
      S_MSUM: begin
        cmd.msum_step = 1'b1;
        if (sts.loop_last) begin
          state_next = S_MDIVS;
        end
      end
      S_MDIVS: begin
        cmd.div_start = 1'b1;
        state_next    = S_MDIV;
      end
      S_MDIV: begin
        if (div_done) begin
          state_next = S_MWB;
        end
      end
      S_MWB: begin
        cmd.med_wb = 1'b1;
        state_next = S_AINIT;
      end
      S_AINIT: begin
        cmd.ainit  = 1'b1;
        state_next = S_ASUM;
      end
      S_ASUM: begin
        cmd.asum_step = 1'b1;
        if (sts.loop_last) begin
          state_next = S_ADIVS;
        end
      end
      S_ADIVS: begin
        cmd.div_start = 1'b1;
        cmd.div_avg   = 1'b1;
        state_next    = S_ADIV;
      end
      S_ADIV: begin
        if (div_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        // Hold until the output register drains
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/echo_distance_median_weighted_filter_core.sv
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_ready   echo_us[19:0]
// out      output     out_valid / out_ready raw_distance, median_distance,
//                                           filtered_distance [14:0] each
// cfg      input      cfg_valid / cfg_ready cfg_index[1:0], cfg_data[17:0]
//
// One request at a time. The bit-serial divider (19 bits wide at the defaults) runs
// once per request when the median window is full, for the weighted average, and
// twice while it fills, for the mean and then the average. Reset clears windows' fill
// counts, the controller and the divider.
// A finished result waits in the output register while the next request is
// taken; work stalls only at the last step if that register is still full.
module echo_distance_median_weighted_filter_core #(
  parameter int MEDIAN_TAPS  = edmwf_pkg::MEDIAN_TAPS_DEF,
  parameter int AVERAGE_TAPS = edmwf_pkg::AVERAGE_TAPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [edmwf_pkg::ECHO_W-1:0]      echo_us,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [edmwf_pkg::DIST_W-1:0]      raw_distance,
  output logic [edmwf_pkg::DIST_W-1:0]      median_distance,
  output logic [edmwf_pkg::DIST_W-1:0]      filtered_distance,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [edmwf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [edmwf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int MSUM_W = edmwf_pkg::DIST_W + $clog2(MEDIAN_TAPS);
  localparam int ADEN_W = $clog2(AVERAGE_TAPS * (AVERAGE_TAPS + 1) / 2 + 1);
  localparam int AWT_W  = edmwf_pkg::DIST_W + ADEN_W;
  localparam int MCNT_W = $clog2(MEDIAN_TAPS + 1);
  localparam int NUM_W  = (MSUM_W > AWT_W) ? MSUM_W : AWT_W;
  localparam int DEN_W  = (MCNT_W > ADEN_W) ? MCNT_W : ADEN_W;

  edmwf_pkg::cmd_t  cmd;
  edmwf_pkg::sts_t  sts;
  logic [NUM_W-1:0] div_num;
  logic [DEN_W-1:0] div_den;
  logic [NUM_W-1:0] div_quot;
  logic             div_done;

  // Registers take a write in any cycle
  assign cfg_ready = 1'b1;

  edmwf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .div_done (div_done),
    .cmd      (cmd)
  );

  edmwf_dp #(
    .MEDIAN_TAPS  (MEDIAN_TAPS),
    .AVERAGE_TAPS (AVERAGE_TAPS),
    .NUM_W        (NUM_W),
    .DEN_W        (DEN_W)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .sts               (sts),
    .echo_us           (echo_us),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .div_num           (div_num),
    .div_den           (div_den),
    .div_quot          (div_quot),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .raw_distance      (raw_distance),
    .median_distance   (median_distance),
    .filtered_distance (filtered_distance)
  );

  edmwf_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .quot  (div_quot),
    .done  (div_done)
  );

endmodule

// File: tb/echo_distance_median_weighted_filter_core_test.sv
`timescale 1ns / 100ps

// Tracks the filter state and the expected distance triples
class filter_scoreboard;

  typedef struct packed {
    logic [edmwf_pkg::DIST_W-1:0] raw;
    logic [edmwf_pkg::DIST_W-1:0] med;
    logic [edmwf_pkg::DIST_W-1:0] filt;
  } dist_set_t;

  logic [edmwf_pkg::SCALE_W-1:0] echo_scale_q;
  logic [edmwf_pkg::DIST_W-1:0]  min_q;
  logic [edmwf_pkg::DIST_W-1:0]  max_q;

  logic [edmwf_pkg::DIST_W-1:0] med_win [edmwf_pkg::MEDIAN_TAPS_DEF];
  int                           med_slot;
  bit                           med_full;
  logic [edmwf_pkg::DIST_W-1:0] avg_win [edmwf_pkg::AVERAGE_TAPS_DEF];
  int                           avg_slot;
  bit                           avg_full;

  dist_set_t pending_q[$];
  int        mismatches;
  int        checked;
  int        accepted;

  function new();
    echo_scale_q = edmwf_pkg::ECHO_SCALE_RST;
    min_q        = edmwf_pkg::MIN_DISTANCE_RST;
    max_q        = edmwf_pkg::MAX_DISTANCE_RST;
    foreach (med_win[i]) med_win[i] = '0;
    foreach (avg_win[i]) avg_win[i] = '0;
    med_slot   = 0;
    med_full   = 1'b0;
    avg_slot   = 0;
    avg_full   = 1'b0;
    mismatches = 0;
    checked    = 0;
    accepted   = 0;
  endfunction

  function void write_reg(logic [edmwf_pkg::CFG_INDEX_W-1:0] idx,
                          logic [edmwf_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      edmwf_pkg::REG_ECHO_SCALE:   echo_scale_q = data[edmwf_pkg::SCALE_W-1:0];
      edmwf_pkg::REG_MIN_DISTANCE: min_q = data[edmwf_pkg::DIST_W-1:0];
      edmwf_pkg::REG_MAX_DISTANCE: max_q = data[edmwf_pkg::DIST_W-1:0];
      default: ;
    endcase
  endfunction

  // Minimum is tested first: with crossed limits, below it gives the minimum, else the maximum
  function logic [edmwf_pkg::DIST_W-1:0] clamp_dist(logic [63:0] d);
    if (d < 64'(min_q)) return min_q;
    if (d > 64'(max_q)) return max_q;
    return d[edmwf_pkg::DIST_W-1:0];
  endfunction

  // Push into the median window; mean of the written entries while filling
  function logic [edmwf_pkg::DIST_W-1:0] push_median(logic [edmwf_pkg::DIST_W-1:0] v);
    logic [edmwf_pkg::DIST_W-1:0] s [edmwf_pkg::MEDIAN_TAPS_DEF];
    logic [edmwf_pkg::DIST_W-1:0] key;
    logic [63:0]                  sum;
    int                           i;
    int                           j;
    med_win[med_slot] = v;
    med_slot++;
    if (med_slot >= edmwf_pkg::MEDIAN_TAPS_DEF) begin
      med_slot = 0;
      med_full = 1'b1;
    end
    if (med_full) begin
      s = med_win;
      for (i = 1; i < edmwf_pkg::MEDIAN_TAPS_DEF; i++) begin
        key = s[i];
        j = i;
        while (j > 0 && s[j-1] > key) begin
          s[j] = s[j-1];
          j--;
        end
        s[j] = key;
      end
      return s[edmwf_pkg::MEDIAN_TAPS_DEF/2];
    end
    sum = '0;
    for (i = 0; i < med_slot; i++) sum += 64'(med_win[i]);
    sum = sum / 64'(med_slot);
    return sum[edmwf_pkg::DIST_W-1:0];
  endfunction

  // Push into the average window; weights n..1 from newest to oldest
  function logic [edmwf_pkg::DIST_W-1:0] push_average(logic [edmwf_pkg::DIST_W-1:0] v);
    logic [63:0] sum;
    logic [63:0] wsum;
    int          n;
    int          i;
    int          pos;
    avg_win[avg_slot] = v;
    avg_slot++;
    if (avg_slot >= edmwf_pkg::AVERAGE_TAPS_DEF) begin
      avg_slot = 0;
      avg_full = 1'b1;
    end
    n = avg_full ? edmwf_pkg::AVERAGE_TAPS_DEF : avg_slot;
    sum  = '0;
    wsum = '0;
    for (i = 0; i < n; i++) begin
      pos = (avg_slot + edmwf_pkg::AVERAGE_TAPS_DEF - 1 - i) % edmwf_pkg::AVERAGE_TAPS_DEF;
      sum  += 64'(avg_win[pos]) * 64'(n - i);
      wsum += 64'(n - i);
    end
    sum = sum / wsum;
    return sum[edmwf_pkg::DIST_W-1:0];
  endfunction

  // Note an accepted echo request and queue its distances
  function void note_echo(logic [edmwf_pkg::ECHO_W-1:0] e);
    dist_set_t   d;
    logic [63:0] scaled;
    scaled = (64'(e) * 64'(echo_scale_q)) >> edmwf_pkg::FRAC_W;
    d.raw  = clamp_dist(scaled);
    d.med  = push_median(d.raw);
    d.filt = push_average(d.med);
    pending_q.push_back(d);
    accepted++;
  endfunction

  task report(string msg);
    if (mismatches < 100) $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Compare one result against the oldest expectation
  task check_result(logic [edmwf_pkg::DIST_W-1:0] raw,
                    logic [edmwf_pkg::DIST_W-1:0] med,
                    logic [edmwf_pkg::DIST_W-1:0] filt);
    dist_set_t want;
    if (pending_q.size() == 0) begin
      report($sformatf("result with no request pending: raw=%0d med=%0d filt=%0d",
                       raw, med, filt));
      return;
    end
    want = pending_q.pop_front();
    checked++;
    if (raw !== want.raw)
      report($sformatf("result %0d raw_distance %0d, want %0d", checked, raw, want.raw));
    if (med !== want.med)
      report($sformatf("result %0d median_distance %0d, want %0d", checked, med, want.med));
    if (filt !== want.filt)
      report($sformatf("result %0d filtered_distance %0d, want %0d",
                       checked, filt, want.filt));
  endtask

endclass

module echo_distance_median_weighted_filter_core_test;

  localparam logic [edmwf_pkg::CFG_INDEX_W-1:0] REG_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;

  logic                              clk;
  logic                              rst;
  logic                              in_valid;
  logic                              in_ready;
  logic [edmwf_pkg::ECHO_W-1:0]      echo_us;
  logic                              out_valid;
  logic                              out_ready;
  logic [edmwf_pkg::DIST_W-1:0]      raw_distance;
  logic [edmwf_pkg::DIST_W-1:0]      median_distance;
  logic [edmwf_pkg::DIST_W-1:0]      filtered_distance;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [edmwf_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [edmwf_pkg::CFG_DATA_W-1:0]  cfg_data;

  filter_scoreboard sb;
  bit               tx_idle_on;
  bit               rx_idle_on;
  bit               quiet_tail;
  int               hold_cycles;
  int               settings_seen;
  int               cycle_count;

  echo_distance_median_weighted_filter_core u_top (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .echo_us           (echo_us),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .raw_distance      (raw_distance),
    .median_distance   (median_distance),
    .filtered_distance (filtered_distance),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending",
               cycle_count, sb.pending_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Check results and stall the output side
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        sb.check_result(raw_distance, median_distance, filtered_distance);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 11) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Offer one echo request and hold it until taken
  task automatic send_echo(input logic [edmwf_pkg::ECHO_W-1:0] e);
    int gap;
    gap = 0;
    if (tx_idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    echo_us  <= e;
    do @(posedge clk); while (!in_ready);
    sb.note_echo(e);
  endtask

  // Keep cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [edmwf_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [edmwf_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic set_config(input int scale, input int min_d, input int max_d);
    write_reg(edmwf_pkg::REG_ECHO_SCALE, edmwf_pkg::CFG_DATA_W'(scale));
    write_reg(edmwf_pkg::REG_MIN_DISTANCE, edmwf_pkg::CFG_DATA_W'(min_d));
    write_reg(edmwf_pkg::REG_MAX_DISTANCE, edmwf_pkg::CFG_DATA_W'(max_d));
    cfg_valid <= 1'b0;
    settings_seen++;
  endtask

  // Stop offering and wait for every pending result
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_q.size() != 0);
  endtask

  // Mostly echoes that land inside the distance range at the current scale
  function automatic logic [edmwf_pkg::ECHO_W-1:0] next_echo();
    logic [63:0] e;
    logic [63:0] target;
    case ($urandom_range(0, 9))
      0, 1: e = $urandom_range(0, 20'hFFFFF);
      2: e = $urandom_range(0, 63);
      default: begin
        target = $urandom_range(0, 32767);
        if (sb.echo_scale_q == '0) e = $urandom_range(0, 20'hFFFFF);
        else e = (target << edmwf_pkg::FRAC_W) / 64'(sb.echo_scale_q)
                 + $urandom_range(0, 3);
        if (e > 64'hFFFFF) e = 64'hFFFFF;
      end
    endcase
    return e[edmwf_pkg::ECHO_W-1:0];
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 64 == 0 && !quiet_tail) begin
        tx_idle_on = $urandom_range(0, 3) != 0;
        rx_idle_on = $urandom_range(0, 3) != 0;
      end
      send_echo(next_echo());
    end
  endtask

  initial begin
    logic [edmwf_pkg::ECHO_W-1:0] edge_echoes [$];
    sb = new();
    tx_idle_on    = 1'b1;
    rx_idle_on    = 1'b1;
    quiet_tail    = 1'b0;
    hold_cycles   = 0;
    settings_seen = 1;
    cycle_count   = 0;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    echo_us   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= edmwf_pkg::REG_ECHO_SCALE;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Field extremes, bit patterns, both clamp edges, ties while filling
    edge_echoes = '{20'd0, 20'hFFFFF, 20'd1, 20'h55555, 20'hAAAAA,
                    20'd117, 20'd118, 20'd119, 20'd23529, 20'd23530, 20'd23531,
                    20'd1000, 20'd1000, 20'd1000, 20'd5000, 20'd200, 20'd9000};
    foreach (edge_echoes[i]) send_echo(edge_echoes[i]);
    run_random(180);

    // Widest scale and open limits; hold the output to back up the input
    drain();
    write_reg(REG_NONE, 18'h3FFFF);
    set_config(262143, 0, 32767);
    send_echo(20'hFFFFF);
    send_echo(20'd0);
    send_echo(20'd1);
    send_echo(20'h7FFFF);
    hold_cycles = 400;
    run_random(250);

    // Zero scale so every request clamps to the minimum; pause mid-phase
    drain();
    set_config(0, 1000, 2000);
    run_random(100);
    drain();
    run_random(100);

    // Crossed limits, then equal limits
    drain();
    set_config(65536, 20000, 10000);
    run_random(200);
    drain();
    set_config(65536, 7777, 7777);
    run_random(150);

    // Tiny scale with the full range open
    drain();
    set_config(1, 0, 32767);
    run_random(100);

    repeat (3) begin
      drain();
      set_config($urandom_range(0, 262143), $urandom_range(0, 32767),
                 $urandom_range(0, 32767));
      run_random(150);
    end

    // Back-to-back traffic at the defaults, no idling
    drain();
    quiet_tail = 1'b1;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    set_config(71303, 128, 25600);
    run_random(250);

    drain();
    repeat (100) @(posedge clk);
    if (sb.pending_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending_q.size()));

    $display("Run covered %0d echo requests over %0d register settings, %0d results checked,",
             sb.accepted, settings_seen, sb.checked);
    $display("including crossed and equal clamp limits, zero and full scale, and output stalls.");
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/edmwf_pkg.sv
hdl/edmwf_div.sv
hdl/edmwf_dp.sv
hdl/edmwf_ctrl.sv
hdl/echo_distance_median_weighted_filter_core.sv
tb/echo_distance_median_weighted_filter_core_test.sv
